### hw/rtl/ptw6_pkg.sv
// Shared constants and types for the six-level page table walker.
package ptw6_pkg;

  localparam int STORE_WORDS_DEFAULT = 4096;
  localparam int LEVEL_COUNT_DEFAULT = 6;
  localparam int INDEX_BITS_DEFAULT = 8;

  localparam int FLAG_BITS = 8;
  localparam int PRESENT_BIT = 0;
  localparam int WORD_SHIFT = 3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WALK = 1'b1;

  typedef struct packed {
    logic read;
    logic write;
  } ptw6_mem_cmd_t;

endpackage

### hw/rtl/page_table_walker_six_level.sv
// Top level of the six-level page table walker.
//
// Channel   Handshake                 Payload
// input     start, accepted if !busy  action, address, write_data
// config    cfg_valid / cfg_ready     cfg_data (root table byte base)
// result    done strobe, one cycle    found, leaf_entry
//
// A write item leaves the walker idle; the store is written at the accepting edge.
// A walk passes through an issue state (store address) and a check state (read
// data check) for each level read, and ends early when a level is not present.
// The result appears on done in the cycle after the last check, while a new item
// may already be accepted. Reset clears the control state and the root register;
// the table store is not cleared. The receiver cannot stall the result.
module page_table_walker_six_level import ptw6_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEFAULT,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
  parameter int INDEX_BITS  = INDEX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] address,
  input  logic [63:0] write_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic        found,
  output logic [63:0] leaf_entry
);

  ptw6_mem_cmd_t                  mem_cmd;
  logic [$clog2(STORE_WORDS)-1:0] mem_addr;
  logic [63:0]                    mem_wdata;
  logic [63:0]                    mem_rdata;

  ptw6_walk #(
    .STORE_WORDS(STORE_WORDS),
    .LEVEL_COUNT(LEVEL_COUNT),
    .INDEX_BITS (INDEX_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .address   (address),
    .write_data(write_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .done      (done),
    .found     (found),
    .leaf_entry(leaf_entry)
  );

  ptw6_store #(
    .STORE_WORDS(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .cmd  (mem_cmd),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

### hw/rtl/ptw6_store.sv
// Table word store: single-port synchronous memory with registered read data.
module ptw6_store import ptw6_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  logic                           clk,
  input  ptw6_mem_cmd_t                  cmd,
  input  logic [$clog2(STORE_WORDS)-1:0] addr,
  input  logic [63:0]                    wdata,
  output logic [63:0]                    rdata
);

  logic [63:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[addr] <= wdata;
    end
    if (cmd.read) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/ptw6_walk.sv
// Walk sequencer: root register, level stepping, store access and result register.
module ptw6_walk import ptw6_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEFAULT,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
  parameter int INDEX_BITS  = INDEX_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [63:0]                    address,
  input  logic [63:0]                    write_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [63:0]                    cfg_data,
  output ptw6_mem_cmd_t                  mem_cmd,
  output logic [$clog2(STORE_WORDS)-1:0] mem_addr,
  output logic [63:0]                    mem_wdata,
  input  logic [63:0]                    mem_rdata,
  output logic                           done,
  output logic                           found,
  output logic [63:0]                    leaf_entry
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVEL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [LVL_W-1:0] level;
  logic [63:0]      vaddr;
  logic [AW-1:0]    base_word;
  logic [AW-1:0]    root_word;
  logic             accept;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && (state == ST_IDLE);
  assign mem_wdata = write_data;

  always_comb begin
    mem_cmd.write = accept && (action == ACT_WRITE);
    mem_cmd.read  = (state == ST_ISSUE);
    if (state == ST_IDLE) begin
      mem_addr = address[WORD_SHIFT +: AW];
    end else begin
      mem_addr = base_word + AW'(vaddr[63 -: INDEX_BITS]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_WALK)) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if ((level == LAST_LEVEL) || !mem_rdata[PRESENT_BIT]) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      root_word <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_CHECK) &&
               ((level == LAST_LEVEL) || !mem_rdata[PRESENT_BIT]);
      if (cfg_valid && cfg_ready) begin
        root_word <= cfg_data[WORD_SHIFT +: AW];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        level     <= '0;
        vaddr     <= address;
        base_word <= root_word;
      end
      ST_ISSUE: begin
        vaddr <= vaddr << INDEX_BITS;
      end
      ST_CHECK: begin
        level     <= level + 1'b1;
        base_word <= {mem_rdata[WORD_SHIFT + AW - 1:FLAG_BITS],
                      {(FLAG_BITS - WORD_SHIFT){1'b0}}};
        if (level == LAST_LEVEL) begin
          found      <= 1'b1;
          leaf_entry <= mem_rdata;
        end else if (!mem_rdata[PRESENT_BIT]) begin
          found      <= 1'b0;
          leaf_entry <= '0;
        end
      end
      default: begin
        level <= '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_after_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_CHECK))
    else $error("Result strobe without a finished walk step.");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_cmd.write |-> (state == ST_IDLE) && !mem_cmd.read)
    else $error("Store write outside the idle state.");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (leaf_entry == '0))
    else $error("Failed walk returned a nonzero entry.");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (level <= LAST_LEVEL))
    else $error("Walk level beyond the last level.");

  a_check_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |=> (state == ST_CHECK))
    else $error("Read data not checked after a store read.");
`endif

endmodule
